### rtl/hprm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall pulse RPM meter package
// Shared widths, constants and register map of the RPM meter.
// ----------------------------------------------------------------------------
package hprm_pkg;

	localparam int GAP_W   = 16;
	localparam int RPM_W   = 19;
	localparam int HIT_W   = 32;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	// 30000 RPM per ms of period, scaled by 16 for four fraction bits
	localparam int RPM_NUMER = 480000;

	localparam logic [GAP_W-1:0] TIMEOUT_RST = 16'd15000;
	localparam logic [GAP_W-1:0] MIN_GAP_RST = 16'd200;

	localparam int HISTORY_DEPTH_DEF  = 20;
	localparam int AVERAGE_WINDOW_DEF = 6;

	// register select: paddr bit 2 picks the word
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_MIN_GAP = 1'b1;

endpackage

### rtl/hprm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// One quotient bit per cycle; a zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module hprm_div #(
	parameter int NW = 24,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] numer,
	input  logic [DW-1:0] denom,
	output logic          busy,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          zero_q;
	logic [CW-1:0] cnt_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= numer;
			rem_q  <= '0;
			den_q  <= denom;
			zero_q <= (denom == '0);
		end else if (cnt_q != '0) begin
			// shift in next dividend bit, subtract when it fits
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = zero_q ? '0 : quo_q;

endmodule

### rtl/hall_pulse_rpm_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall pulse RPM meter
// Tachometer from sensor pulse periods, with latest and averaged RPM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one beat per millisecond tick (in_valid / in_stall), with
//   edge_seen set when a falling sensor edge came in that tick. Every other
//   edge is a candidate; it counts as a pulse when the elapsed time exceeds
//   min_gap_ms. Elapsed time reaching timeout_ms records a zero gap.
//   Output channel: one beat per tick (out_valid / out_stall) with the latest
//   and averaged RPM (4 fraction bits), the wrapping hit count and the pulse
//   flag of that tick.
//   An accepted tick has its window of gaps walked, then both bit-serial
//   dividers run, retiring one quotient bit per cycle, and the result loads
//   the output register. NUM_W is the width of the averaged numerator and
//   sets the length of the averaged division. A new tick can be taken once
//   the previous one is loaded into the output register, so one result may
//   wait for the receiver while the next is computed.
//   A stalled result holds until taken; the finished tick after it then
//   waits in the sequencer and the input side stalls.
//   Reset clears timing, the gap history, the latest gap and the hit count,
//   and loads timeout_ms = 15000 and min_gap_ms = 200.
//   Registers: APB word 0 timeout_ms, word 1 min_gap_ms (16 bits each);
//   write them only while no tick is in flight.
// ----------------------------------------------------------------------------
module hall_pulse_rpm_meter_unit #(
	parameter int HISTORY_DEPTH  = hprm_pkg::HISTORY_DEPTH_DEF,
	parameter int AVERAGE_WINDOW = hprm_pkg::AVERAGE_WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hprm_pkg::APB_AW-1:0] paddr,
	input  logic [hprm_pkg::APB_DW-1:0] pwdata,
	output logic [hprm_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	// tick input
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        edge_seen,
	// result output
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [hprm_pkg::RPM_W-1:0]  latest_rpm_q4,
	output logic [hprm_pkg::RPM_W-1:0]  average_rpm_q4,
	output logic [hprm_pkg::HIT_W-1:0]  hit_count,
	output logic                        pulse_accepted
);

	localparam int GW    = hprm_pkg::GAP_W;
	localparam int RPW   = hprm_pkg::RPM_W;
	localparam int HW    = hprm_pkg::HIT_W;
	localparam int WIN   = (AVERAGE_WINDOW < HISTORY_DEPTH) ? AVERAGE_WINDOW : HISTORY_DEPTH;
	localparam int CNT_W = $clog2(WIN + 1);
	localparam int SUM_W = GW + CNT_W;
	localparam int NUM_W = $clog2(hprm_pkg::RPM_NUMER * WIN + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SUM  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} st_t;

	st_t state_q;

	// configuration
	logic [GW-1:0] timeout_q;
	logic [GW-1:0] min_gap_q;
	logic          cfg_wr;

	// tick state
	logic [GW-1:0] elapsed_q;
	logic          skip_q;
	logic [GW-1:0] hist_q [HISTORY_DEPTH];
	logic [GW-1:0] latest_q;
	logic [HW-1:0] total_q;
	logic          acc_q;

	// window walk
	logic [GW-1:0]    win_q [WIN];
	logic [CNT_W-1:0] step_q;
	logic [SUM_W-1:0] sum_q;
	logic [NUM_W-1:0] num_q;

	// output register
	logic           out_valid_q;
	logic [RPW-1:0] out_lat_q;
	logic [RPW-1:0] out_avg_q;
	logic [HW-1:0]  out_hit_q;
	logic           out_acc_q;

	// tick decode
	logic          in_beat;
	logic [GW:0]   e_inc;
	logic [GW-1:0] e_sat;
	logic          take;
	logic          tmo;
	logic          push;
	logic [GW-1:0] push_gap;
	logic [GW-1:0] hist_nx [HISTORY_DEPTH];

	logic           div_start;
	logic           lat_busy;
	logic           avg_busy;
	logic [RPW-1:0] lat_quo;
	logic [NUM_W-1:0] avg_quo;
	logic           out_load;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= hprm_pkg::TIMEOUT_RST;
			min_gap_q <= hprm_pkg::MIN_GAP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				hprm_pkg::REG_TIMEOUT: timeout_q <= pwdata[GW-1:0];
				hprm_pkg::REG_MIN_GAP: min_gap_q <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			hprm_pkg::REG_TIMEOUT: prdata = {(hprm_pkg::APB_DW - GW)'(0), timeout_q};
			hprm_pkg::REG_MIN_GAP: prdata = {(hprm_pkg::APB_DW - GW)'(0), min_gap_q};
			default:               prdata = '0;
		endcase
	end

	// ---------------- tick update ----------------
	assign in_stall = (state_q != ST_IDLE);
	assign in_beat  = in_valid && !in_stall;

	// elapsed + 1, saturating at the top of the gap range
	assign e_inc    = {1'b0, elapsed_q} + (GW + 1)'(1);
	assign e_sat    = e_inc[GW] ? '1 : e_inc[GW-1:0];
	assign take     = edge_seen && !skip_q && (e_sat > min_gap_q);
	assign tmo      = !take && (e_sat >= timeout_q);
	assign push     = take || tmo;
	assign push_gap = take ? e_sat : '0;

	// history after this tick: oldest at 0, newest at the top
	always_comb begin
		for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
			hist_nx[i] = push ? hist_q[i+1] : hist_q[i];
		end
		hist_nx[HISTORY_DEPTH-1] = push ? push_gap : hist_q[HISTORY_DEPTH-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			skip_q    <= 1'b0;
			latest_q  <= '0;
			total_q   <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (in_beat) begin
			elapsed_q <= push ? '0 : e_sat;
			// every edge flips the skip flag, taken or not
			skip_q    <= skip_q ^ edge_seen;
			if (take) begin
				latest_q <= e_sat;
				total_q  <= total_q + HW'(1);
			end
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= hist_nx[i];
			end
		end
	end

	// ---------------- sequencer ----------------
	assign div_start = (state_q == ST_SUM) && (step_q == '0);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_beat)                 state_q <= ST_SUM;
				ST_SUM:  if (step_q == '0)            state_q <= ST_DIV;
				ST_DIV:  if (!lat_busy && !avg_busy)  state_q <= ST_OUT;
				ST_OUT:  if (out_load)                state_q <= ST_IDLE;
				default:                              state_q <= ST_IDLE;
			endcase
		end
	end

	// walk the newest WIN gaps, one a cycle, through a shift line
	always_ff @(posedge clk) begin
		if (in_beat) begin
			acc_q  <= take;
			step_q <= CNT_W'(WIN);
			sum_q  <= '0;
			num_q  <= '0;
			for (int i = 0; i < WIN; i++) begin
				win_q[i] <= hist_nx[HISTORY_DEPTH - WIN + i];
			end
		end else if (state_q == ST_SUM && step_q != '0) begin
			// only positive gaps count toward the average
			if (win_q[0] != '0) begin
				sum_q <= sum_q + SUM_W'(win_q[0]);
				num_q <= num_q + NUM_W'(hprm_pkg::RPM_NUMER);
			end
			for (int i = 0; i < WIN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN-1] <= '0;
			step_q       <= step_q - CNT_W'(1);
		end
	end

	// ---------------- dividers ----------------
	hprm_div #(
		.NW (RPW),
		.DW (GW)
	) u_lat_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (RPW'(hprm_pkg::RPM_NUMER)),
		.denom  (latest_q),
		.busy   (lat_busy),
		.quo    (lat_quo)
	);

	hprm_div #(
		.NW (NUM_W),
		.DW (SUM_W)
	) u_avg_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (num_q),
		.denom  (sum_q),
		.busy   (avg_busy),
		.quo    (avg_quo)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_lat_q <= lat_quo;
			out_avg_q <= avg_quo[RPW-1:0];
			out_hit_q <= total_q;
			out_acc_q <= acc_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign latest_rpm_q4  = out_lat_q;
	assign average_rpm_q4 = out_avg_q;
	assign hit_count      = out_hit_q;
	assign pulse_accepted = out_acc_q;

endmodule

### rtl/hprm_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPM meter port checker
// Watches the top level's ports and flags behavior out of contract.
// ----------------------------------------------------------------------------
module hprm_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [hprm_pkg::RPM_W-1:0] latest_rpm_q4,
	input logic [hprm_pkg::RPM_W-1:0] average_rpm_q4,
	input logic [hprm_pkg::HIT_W-1:0] hit_count,
	input logic                       pulse_accepted
);

	localparam logic [hprm_pkg::RPM_W-1:0] RPM_MAX = hprm_pkg::RPM_W'(hprm_pkg::RPM_NUMER);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(latest_rpm_q4)
			&& $stable(average_rpm_q4) && $stable(hit_count) && $stable(pulse_accepted))
		else $error("stalled result beat changed");

	// one tick at a time: a taken tick blocks the next cycle
	a_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("tick taken while previous tick in flight");

	// a counted pulse leaves a positive gap, so both speeds are nonzero
	a_pulse_rpm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse_accepted |-> latest_rpm_q4 != '0 && average_rpm_q4 != '0)
		else $error("pulse beat with zero speed");

	// speeds never exceed the one-millisecond period value
	a_rpm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> latest_rpm_q4 <= RPM_MAX && average_rpm_q4 <= RPM_MAX)
		else $error("speed out of range");

endmodule

bind hall_pulse_rpm_meter_unit hprm_chk u_hprm_chk (.*);
